### hw/rtl/gsjr_pkg.sv
// Shared types and constants for the scalar split and joint recoder.
`timescale 1ns / 1ps
package gsjr_pkg;

    localparam int SCALAR_BITS_DEF = 64;
    localparam int DIGITS_DEF      = 64;
    localparam int ACC_W           = 136;
    localparam int Y_W             = 97;
    localparam int DIV_BITS        = 96;
    localparam int COEF_W          = 33;
    localparam int PART_W          = 64;
    localparam int REC_CAP         = 80;
    localparam int CNT_W           = 7;
    localparam int POS_W           = 6;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASIS_A     = 2'd0,
        CFG_BASIS_B     = 2'd1,
        CFG_GROUP_ORDER = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_K,
        OP_MAC_INIT,
        OP_MAC_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIX,
        OP_SAVE_PART,
        OP_REC_LOAD,
        OP_REC_STEP,
        OP_SINGLE
    } dp_op_t;

    typedef enum logic [1:0] {
        COEF_SUM,
        COEF_A,
        COEF_B
    } coef_sel_t;

    typedef enum logic [1:0] {
        MULT_K,
        MULT_Y1,
        MULT_Y2
    } mult_sel_t;

    typedef enum logic [1:0] {
        ACC_CLEAR,
        ACC_LOAD_K,
        ACC_KEEP
    } acc_mode_t;

    typedef struct packed {
        dp_op_t     op;
        coef_sel_t  coef_sel;
        mult_sel_t  mult_sel;
        acc_mode_t  acc_mode;
        logic       sub;
        logic       msb;
        logic       sel_second;
        logic       emit;
        logic [POS_W-1:0] pos;
        logic       last;
        logic       no_digits;
        logic       overflow;
    } dp_cmd_t;

    typedef struct packed {
        logic parts_fit;
        logic parts_zero;
        logic rec_zero;
    } dp_stat_t;

endpackage

### hw/rtl/gsjr_dp.sv
// Datapath: serial multiply-accumulate, restoring divider, and joint digit recoder.
`timescale 1ns / 1ps
module gsjr_dp
    import gsjr_pkg::*;
#(
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [63:0]         scalar,
    input  logic [31:0]         basis_a,
    input  logic [31:0]         basis_b,
    input  logic [63:0]         group_order,
    output dp_stat_t            stat,
    output logic                strobe,
    output logic signed [1:0]   digit_first,
    output logic signed [1:0]   digit_second,
    output logic [POS_W-1:0]    position,
    output logic                last,
    output logic                no_digits,
    output logic                overflow
);

    logic [SCALAR_BITS-1:0] k_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       mul_reg;
    logic [COEF_W-1:0]      cf_reg;
    logic                   sub_reg;
    logic [DIV_BITS-1:0]    dv_reg;
    logic [PART_W-1:0]      rm_reg;
    logic                   neg_reg;
    logic [Y_W-1:0]         y1_reg;
    logic [Y_W-1:0]         y2_reg;
    logic [PART_W-1:0]      k1_reg;
    logic [PART_W-1:0]      k2_reg;
    logic                   fit1_reg;
    logic                   fit2_reg;
    logic [PART_W-1:0]      p1_reg;
    logic [PART_W-1:0]      p2_reg;

    logic                   strobe_reg;
    logic                   strobe_next;
    logic [1:0]             df_reg;
    logic [1:0]             ds_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   last_reg;
    logic                   nd_reg;
    logic                   ov_reg;

    logic [COEF_W-1:0]      coef_sum;
    logic [COEF_W-1:0]      coef_mux;
    logic [ACC_W-1:0]       mult_mux;
    logic                   mac_neg;
    logic [ACC_W-1:0]       mac_sum;
    logic [ACC_W-1:0]       acc_mag;
    logic [PART_W:0]        rm_shift;
    logic                   rm_ge;
    logic [PART_W:0]        rm_sub;
    logic [Y_W-1:0]         q_ext;
    logic [Y_W-1:0]         q_adj;
    logic [Y_W-1:0]         y_fix;
    logic                   acc_fit;
    logic                   neg1;
    logic                   neg2;
    logic [1:0]             dig1;
    logic [1:0]             dig2;
    logic [PART_W-1:0]      p1_next;
    logic [PART_W-1:0]      p2_next;

    assign coef_sum = {basis_a[31], basis_a} + {basis_b[31], basis_b};

    always_comb
    begin
        case (cmd.coef_sel)
            COEF_SUM: coef_mux = coef_sum;
            COEF_A:   coef_mux = {basis_a[31], basis_a};
            COEF_B:   coef_mux = {basis_b[31], basis_b};
            default:  coef_mux = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.mult_sel)
            MULT_K:  mult_mux = {{(ACC_W-SCALAR_BITS){1'b0}}, k_reg};
            MULT_Y1: mult_mux = {{(ACC_W-Y_W){y1_reg[Y_W-1]}}, y1_reg};
            MULT_Y2: mult_mux = {{(ACC_W-Y_W){y2_reg[Y_W-1]}}, y2_reg};
            default: mult_mux = '0;
        endcase
    end

    // The top coefficient bit carries negative weight.
    assign mac_neg = sub_reg ^ cmd.msb;
    assign mac_sum = acc_reg + (mul_reg ^ {ACC_W{mac_neg}}) + ACC_W'(mac_neg);

    assign acc_mag = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;

    assign rm_shift = {rm_reg, dv_reg[DIV_BITS-1]};
    assign rm_ge    = rm_shift >= {1'b0, group_order};
    assign rm_sub   = rm_shift - {1'b0, group_order};

    // Floor rounding: a negative dividend with a remainder steps one further down.
    assign q_ext = {1'b0, dv_reg};
    assign q_adj = q_ext + Y_W'(rm_reg != '0);
    assign y_fix = neg_reg ? (~q_adj + Y_W'(1)) : q_ext;

    assign acc_fit = (&acc_reg[ACC_W-1:PART_W-1]) | ~(|acc_reg[ACC_W-1:PART_W-1]);

    always_comb
    begin
        neg1 = 1'b0;
        neg2 = 1'b0;
        if (p1_reg[0] && p2_reg[0])
        begin
            neg1 = p1_reg[1];
            neg2 = p2_reg[1];
        end
        else if ((p1_reg[0] != p2_reg[0]) && (p1_reg[1] != p2_reg[1]))
        begin
            neg1 = p1_reg[0];
            neg2 = p2_reg[0];
        end
        dig1 = p1_reg[0] ? (neg1 ? 2'b11 : 2'b01) : 2'b00;
        dig2 = p2_reg[0] ? (neg2 ? 2'b11 : 2'b01) : 2'b00;
        p1_next = {p1_reg[PART_W-1], p1_reg[PART_W-1:1]} + PART_W'(neg1);
        p2_next = {p2_reg[PART_W-1], p2_reg[PART_W-1:1]} + PART_W'(neg2);
    end

    assign stat.parts_fit  = fit1_reg & fit2_reg;
    assign stat.parts_zero = (k1_reg == '0) && (k2_reg == '0);
    assign stat.rec_zero   = (p1_reg == '0) && (p2_reg == '0);

    assign strobe_next = ((cmd.op == OP_REC_STEP) && cmd.emit) || (cmd.op == OP_SINGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD_K:
            begin
                k_reg <= scalar[SCALAR_BITS-1:0];
            end
            OP_MAC_INIT:
            begin
                cf_reg  <= coef_mux;
                mul_reg <= mult_mux;
                sub_reg <= cmd.sub;
                case (cmd.acc_mode)
                    ACC_CLEAR:  acc_reg <= '0;
                    ACC_LOAD_K: acc_reg <= {{(ACC_W-SCALAR_BITS){1'b0}}, k_reg};
                    default:    acc_reg <= acc_reg;
                endcase
            end
            OP_MAC_STEP:
            begin
                if (cf_reg[0])
                begin
                    acc_reg <= mac_sum;
                end
                mul_reg <= {mul_reg[ACC_W-2:0], 1'b0};
                cf_reg  <= {1'b0, cf_reg[COEF_W-1:1]};
            end
            OP_DIV_INIT:
            begin
                neg_reg <= acc_reg[ACC_W-1];
                dv_reg  <= acc_mag[DIV_BITS-1:0];
                rm_reg  <= '0;
            end
            OP_DIV_STEP:
            begin
                rm_reg <= rm_ge ? rm_sub[PART_W-1:0] : rm_shift[PART_W-1:0];
                dv_reg <= {dv_reg[DIV_BITS-2:0], rm_ge};
            end
            OP_DIV_FIX:
            begin
                if (cmd.sel_second)
                begin
                    y2_reg <= y_fix;
                end
                else
                begin
                    y1_reg <= y_fix;
                end
            end
            OP_SAVE_PART:
            begin
                if (cmd.sel_second)
                begin
                    k2_reg   <= acc_reg[PART_W-1:0];
                    fit2_reg <= acc_fit;
                end
                else
                begin
                    k1_reg   <= acc_reg[PART_W-1:0];
                    fit1_reg <= acc_fit;
                end
            end
            OP_REC_LOAD:
            begin
                p1_reg <= k1_reg;
                p2_reg <= k2_reg;
            end
            OP_REC_STEP:
            begin
                p1_reg   <= p1_next;
                p2_reg   <= p2_next;
                df_reg   <= dig1;
                ds_reg   <= dig2;
                pos_reg  <= cmd.pos;
                last_reg <= cmd.last;
                nd_reg   <= 1'b0;
                ov_reg   <= 1'b0;
            end
            OP_SINGLE:
            begin
                df_reg   <= 2'b00;
                ds_reg   <= 2'b00;
                pos_reg  <= '0;
                last_reg <= 1'b1;
                nd_reg   <= cmd.no_digits;
                ov_reg   <= cmd.overflow;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign strobe       = strobe_reg;
    assign digit_first  = df_reg;
    assign digit_second = ds_reg;
    assign position     = pos_reg;
    assign last         = last_reg;
    assign no_digits    = nd_reg;
    assign overflow     = ov_reg;

endmodule

### hw/rtl/gsjr_ctrl.sv
// Controller: sequences the split, the digit count pass and the emit pass.
`timescale 1ns / 1ps
module gsjr_ctrl
    import gsjr_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     group_zero,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL1_INIT, S_MUL1, S_DIV1_INIT, S_DIV1, S_FIX1,
        S_MUL2_INIT, S_MUL2, S_DIV2_INIT, S_DIV2, S_FIX2,
        S_K2A_INIT, S_K2A, S_K2B_INIT, S_K2B, S_SAVE2,
        S_K1A_INIT, S_K1A, S_K1B_INIT, S_K1B, S_SAVE1,
        S_CHECK, S_COUNT, S_DECIDE, S_EMIT, S_SINGLE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   step_reg;
    logic [CNT_W-1:0]   step_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [POS_W-1:0]   idx_reg;
    logic [POS_W-1:0]   idx_next;
    logic               nd_reg;
    logic               nd_next;
    logic               ov_reg;
    logic               ov_next;
    logic               mac_done;
    logic               div_done;
    logic               emit_last;

    assign mac_done  = step_reg == CNT_W'(COEF_W - 1);
    assign div_done  = step_reg == CNT_W'(DIV_BITS - 1);
    assign emit_last = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + CNT_W'(1);
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        nd_next    = nd_reg;
        ov_next    = ov_reg;
        cmd        = '{op: OP_NOP, coef_sel: COEF_SUM, mult_sel: MULT_K,
                       acc_mode: ACC_KEEP, default: '0};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op  = OP_LOAD_K;
                    nd_next = 1'b0;
                    ov_next = group_zero;
                    state_next = group_zero ? S_SINGLE : S_MUL1_INIT;
                end
            end
            S_MUL1_INIT:
            begin
                cmd.op       = OP_MAC_INIT;
                cmd.coef_sel = COEF_SUM;
                cmd.mult_sel = MULT_K;
                cmd.acc_mode = ACC_CLEAR;
                step_next    = '0;
                state_next   = S_MUL1;
            end
            S_MUL2_INIT:
            begin
                cmd.op       = OP_MAC_INIT;
                cmd.coef_sel = COEF_B;
                cmd.mult_sel = MULT_K;
                cmd.acc_mode = ACC_CLEAR;
                cmd.sub      = 1'b1;
                step_next    = '0;
                state_next   = S_MUL2;
            end
            S_K2A_INIT:
            begin
                cmd.op       = OP_MAC_INIT;
                cmd.coef_sel = COEF_SUM;
                cmd.mult_sel = MULT_Y2;
                cmd.acc_mode = ACC_CLEAR;
                cmd.sub      = 1'b1;
                step_next    = '0;
                state_next   = S_K2A;
            end
            S_K2B_INIT:
            begin
                cmd.op       = OP_MAC_INIT;
                cmd.coef_sel = COEF_B;
                cmd.mult_sel = MULT_Y1;
                cmd.sub      = 1'b1;
                step_next    = '0;
                state_next   = S_K2B;
            end
            S_K1A_INIT:
            begin
                cmd.op       = OP_MAC_INIT;
                cmd.coef_sel = COEF_SUM;
                cmd.mult_sel = MULT_Y1;
                cmd.acc_mode = ACC_LOAD_K;
                cmd.sub      = 1'b1;
                step_next    = '0;
                state_next   = S_K1A;
            end
            S_K1B_INIT:
            begin
                cmd.op       = OP_MAC_INIT;
                cmd.coef_sel = COEF_A;
                cmd.mult_sel = MULT_Y2;
                cmd.sub      = 1'b1;
                step_next    = '0;
                state_next   = S_K1B;
            end
            S_MUL1, S_MUL2, S_K2A, S_K2B, S_K1A, S_K1B:
            begin
                cmd.op  = OP_MAC_STEP;
                cmd.msb = mac_done;
                if (mac_done)
                begin
                    case (state_reg)
                        S_MUL1:  state_next = S_DIV1_INIT;
                        S_MUL2:  state_next = S_DIV2_INIT;
                        S_K2A:   state_next = S_K2B_INIT;
                        S_K2B:   state_next = S_SAVE2;
                        S_K1A:   state_next = S_K1B_INIT;
                        default: state_next = S_SAVE1;
                    endcase
                end
            end
            S_DIV1_INIT, S_DIV2_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                step_next  = '0;
                state_next = (state_reg == S_DIV1_INIT) ? S_DIV1 : S_DIV2;
            end
            S_DIV1, S_DIV2:
            begin
                cmd.op = OP_DIV_STEP;
                if (div_done)
                begin
                    state_next = (state_reg == S_DIV1) ? S_FIX1 : S_FIX2;
                end
            end
            S_FIX1:
            begin
                cmd.op     = OP_DIV_FIX;
                state_next = S_MUL2_INIT;
            end
            S_FIX2:
            begin
                cmd.op         = OP_DIV_FIX;
                cmd.sel_second = 1'b1;
                state_next     = S_K2A_INIT;
            end
            S_SAVE2:
            begin
                cmd.op         = OP_SAVE_PART;
                cmd.sel_second = 1'b1;
                state_next     = S_K1A_INIT;
            end
            S_SAVE1:
            begin
                cmd.op     = OP_SAVE_PART;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.parts_fit)
                begin
                    ov_next    = 1'b1;
                    state_next = S_SINGLE;
                end
                else if (stat.parts_zero)
                begin
                    nd_next    = 1'b1;
                    state_next = S_SINGLE;
                end
                else
                begin
                    cmd.op     = OP_REC_LOAD;
                    cnt_next   = '0;
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                // Dry run: count digit pairs before any is sent.
                if (stat.rec_zero || (cnt_reg == CNT_W'(REC_CAP)))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.op   = OP_REC_STEP;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DECIDE:
            begin
                if (!stat.rec_zero || (cnt_reg > CNT_W'(DIGITS)))
                begin
                    ov_next    = 1'b1;
                    state_next = S_SINGLE;
                end
                else
                begin
                    cmd.op     = OP_REC_LOAD;
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.op   = OP_REC_STEP;
                cmd.emit = 1'b1;
                cmd.pos  = idx_reg;
                cmd.last = emit_last;
                idx_next = idx_reg + POS_W'(1);
                if (emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SINGLE:
            begin
                cmd.op        = OP_SINGLE;
                cmd.no_digits = nd_reg;
                cmd.overflow  = ov_reg;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            nd_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            nd_reg    <= nd_next;
            ov_reg    <= ov_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

### hw/rtl/glv_scalar_joint_recode.sv
// Split: six serial multiply-accumulates, two restoring divisions, two saves and one
// check; then a count pass, one decide state and an emit pass that sends pair i at
// position i (n pairs).
// A new scalar is taken only when idle; a zero group order goes straight to the lone flag
// beat. The shared accumulator and divider set the pace.
// Results leave one per cycle with a strobe; the receiver cannot stall them.
// Reset (rst_n low, asynchronous): idle, no strobe, a = b = 0, group order = 1.
`timescale 1ns / 1ps
module glv_scalar_joint_recode
    import gsjr_pkg::*;
#(
    parameter int SCALAR_BITS = SCALAR_BITS_DEF,
    parameter int DIGITS      = DIGITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [63:0]           scalar,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]           cfg_data,
    output logic                  strobe,
    output logic signed [1:0]     digit_first,
    output logic signed [1:0]     digit_second,
    output logic [POS_W-1:0]      position,
    output logic                  last,
    output logic                  no_digits,
    output logic                  overflow
);

    logic [31:0] basis_a_reg;
    logic [31:0] basis_b_reg;
    logic [63:0] group_order_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_a_reg     <= '0;
            basis_b_reg     <= '0;
            group_order_reg <= 64'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASIS_A:     basis_a_reg     <= cfg_data[31:0];
                CFG_BASIS_B:     basis_b_reg     <= cfg_data[31:0];
                CFG_GROUP_ORDER: group_order_reg <= cfg_data;
                default:         group_order_reg <= group_order_reg;
            endcase
        end
    end

    gsjr_ctrl #(
        .DIGITS(DIGITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .group_zero (group_order_reg == '0),
        .stat       (stat),
        .busy       (busy),
        .cmd        (cmd)
    );

    gsjr_dp #(
        .SCALAR_BITS(SCALAR_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .scalar       (scalar),
        .basis_a      (basis_a_reg),
        .basis_b      (basis_b_reg),
        .group_order  (group_order_reg),
        .stat         (stat),
        .strobe       (strobe),
        .digit_first  (digit_first),
        .digit_second (digit_second),
        .position     (position),
        .last         (last),
        .no_digits    (no_digits),
        .overflow     (overflow)
    );

`ifndef SYNTH
    a_flag_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (no_digits || overflow) |-> last && position == '0)
        else $error("flagged beat is not a lone final beat");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(no_digits && overflow))
        else $error("no_digits and overflow both set");

    a_pairs_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && position == $past(position) + 1'b1)
        else $error("digit pair beats not contiguous");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || strobe)
        else $error("accepted scalar left no trace");
`endif

endmodule

### sim/glv_scalar_joint_recode_tb.sv
// Self-checking testbench for the scalar split and joint signed-digit recoder.
`timescale 1ns / 1ps
module glv_scalar_joint_recode_tb;
    import gsjr_pkg::*;

    typedef struct {
        logic signed [1:0] d1;
        logic signed [1:0] d2;
        logic [5:0]        pos;
        logic              last;
        logic              nd;
        logic              ov;
    } digit_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [63:0] scalar = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BASIS_A;
    logic [63:0] cfg_data = '0;
    logic strobe;
    logic signed [1:0] digit_first;
    logic signed [1:0] digit_second;
    logic [POS_W-1:0] position;
    logic last;
    logic no_digits;
    logic overflow;

    logic [63:0] pending_scalars[$];
    digit_pair_t expected_pairs[$];
    logic signed [31:0] lat_a = '0;
    logic signed [31:0] lat_b = '0;
    logic [63:0] order_n = 64'd1;
    int send_idle_pct = 0;
    int errors = 0;
    int cycles = 0;

    glv_scalar_joint_recode dut (.*);

    always #1 clk = ~clk;

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic void push_single(input logic nd, input logic ov);
        digit_pair_t e;
        e.d1 = '0;
        e.d2 = '0;
        e.pos = '0;
        e.last = 1'b1;
        e.nd = nd;
        e.ov = ov;
        expected_pairs.push_back(e);
    endfunction

    function automatic logic signed [255:0] floor_div(input logic signed [255:0] x,
                                                      input logic [63:0] n);
        logic signed [255:0] nn;
        logic signed [255:0] q;
        nn = {192'b0, n};
        q = x / nn;
        if (x < 0 && (x % nn) != 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit fits64(input logic signed [255:0] v);
        logic signed [255:0] t;
        t = $signed(v[63:0]);
        return t == v;
    endfunction

    // Split k with the lattice values and push the recoded digit pairs, or a lone flag beat.
    function automatic void predict_digits(input logic [63:0] k);
        logic signed [255:0] wk, wa, wb, y1, y2, k1, k2;
        logic signed [63:0] p1, p2;
        int d1, d2, cnt;
        int da[80];
        int db[80];
        digit_pair_t e;
        wk = {192'b0, k};
        wa = 256'(lat_a);
        wb = 256'(lat_b);
        cnt = 0;
        if (order_n == 0)
        begin
            push_single(1'b0, 1'b1);
            return;
        end
        y1 = floor_div(wk * (wa + wb), order_n);
        y2 = floor_div(-(wk * wb), order_n);
        k2 = -(wa * y2 + wb * y1 + wb * y2);
        k1 = wk - (wa * y1 - wb * y2) + k2;
        if (!fits64(k1) || !fits64(k2))
        begin
            push_single(1'b0, 1'b1);
            return;
        end
        p1 = k1[63:0];
        p2 = k2[63:0];
        if (p1 == 0 && p2 == 0)
        begin
            push_single(1'b1, 1'b0);
            return;
        end
        while ((p1 != 0 || p2 != 0) && cnt < 80)
        begin
            d1 = int'(p1[0]);
            d2 = int'(p2[0]);
            if (d1 == 1 && d2 == 1)
            begin
                if (p1[1]) d1 = -1;
                if (p2[1]) d2 = -1;
            end
            else if (d1 != d2 && p1[1] != p2[1])
            begin
                d1 = -d1;
                d2 = -d2;
            end
            p1 = (p1 >>> 1) + ((d1 == -1) ? 64'sd1 : 64'sd0);
            p2 = (p2 >>> 1) + ((d2 == -1) ? 64'sd1 : 64'sd0);
            da[cnt] = d1;
            db[cnt] = d2;
            cnt++;
        end
        if (p1 != 0 || p2 != 0 || cnt > 64)
        begin
            push_single(1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < cnt; i++)
        begin
            e.d1 = 2'(da[i]);
            e.d2 = 2'(db[i]);
            e.pos = 6'(i);
            e.last = (i == cnt - 1);
            e.nd = 1'b0;
            e.ov = 1'b0;
            expected_pairs.push_back(e);
        end
    endfunction

    // Driver: record accepted scalars, then present the next one or idle.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (start && !busy)
                predict_digits(scalar);
            if (!start || !busy)
            begin
                if (pending_scalars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    start <= 1'b1;
                    scalar <= pending_scalars.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed pair must match the oldest expectation.
    always @(posedge clk)
    begin
        digit_pair_t e;
        if (rst_n && strobe)
        begin
            if (expected_pairs.size() == 0)
                report("digit pair with nothing expected");
            else
            begin
                e = expected_pairs.pop_front();
                if (digit_first !== e.d1)
                    report($sformatf("digit_first %0d, want %0d", digit_first, e.d1));
                if (digit_second !== e.d2)
                    report($sformatf("digit_second %0d, want %0d", digit_second, e.d2));
                if (position !== e.pos)
                    report($sformatf("position %0d, want %0d", position, e.pos));
                if (last !== e.last)
                    report($sformatf("last %b, want %b", last, e.last));
                if (no_digits !== e.nd)
                    report($sformatf("no_digits %b, want %b", no_digits, e.nd));
                if (overflow !== e.ov)
                    report($sformatf("overflow %b, want %b", overflow, e.ov));
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 3000000)
        begin
            $display("timeout");
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        // hold until ready is seen, the beat lands on the next edge
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BASIS_A: lat_a = value[31:0];
            CFG_BASIS_B: lat_b = value[31:0];
            default:     order_n = value;
        endcase
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_scalars.size() != 0 || start || busy || expected_pairs.size() != 0);
        // an overflow scalar may still be in flight after its single result
        repeat (450) @(posedge clk);
    endtask

    task automatic set_lattice(input logic [31:0] a, input logic [31:0] b,
                               input logic [63:0] n);
        write_reg(CFG_BASIS_A, {$urandom, a});
        write_reg(CFG_BASIS_B, {$urandom, b});
        write_reg(CFG_GROUP_ORDER, n);
    endtask

    function automatic logic [63:0] rand_scalar();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return {32'b0, $urandom};
            2: return 64'($urandom_range(255));
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    initial
    begin
        logic [63:0] n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // plain split: first part is the scalar itself
        set_lattice(32'd0, 32'd0, 64'd1);
        pending_scalars = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd5, 64'd7, 64'h7fff_ffff_ffff_ffff,
                            64'h8000_0000_0000_0000, '1, 64'haaaa_aaaa_aaaa_aaaa,
                            64'h5555_5555_5555_5555, 64'h3f};
        drain();
        // zero divisor
        set_lattice(32'd1, 32'd1, 64'd0);
        pending_scalars = '{64'd0, 64'd9, '1};
        drain();
        set_lattice(32'h8000_0000, 32'h7fff_ffff, '1);
        pending_scalars = '{64'd0, 64'd1, '1, 64'h1234_5678_9abc_def0};
        drain();
        set_lattice(32'h7fff_ffff, 32'h8000_0000, 64'd1);
        pending_scalars = '{64'd1, '1, 64'd77};
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 77;
                2: send_idle_pct = 0;
                default: send_idle_pct = 35;
            endcase
            case ($urandom_range(3))
                0: n = {$urandom, $urandom};
                1: n = 64'($urandom_range(1, 1000));
                2: n = {32'b0, $urandom} | 64'd1;
                default: n = $urandom_range(1) ? '1 : 64'd1;
            endcase
            set_lattice($urandom >> $urandom_range(31), -($urandom >> $urandom_range(31)), n);
            for (int i = 0; i < 52; i++)
                pending_scalars.push_back(rand_scalar());
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
